FILE: hdl/ptnm_pkg.sv
// shared types, constants and codes for the palette tint nearest match block
// no dependencies
package ptnm_pkg;

    localparam int unsigned PALETTE_ENTRIES_DEF = 256;

    localparam int CH_W     = 16;
    localparam int IDX_W    = 8;
    localparam int PCT_W    = 11;
    localparam int DIST_W   = 32;
    localparam int ADDR_W   = 4;
    localparam int DATA_W   = 32;
    localparam int NUM_CH   = 3;
    localparam int COLOR_W  = NUM_CH * CH_W;

    // tint arithmetic: c * (100 + pct), then divide by 100 via reciprocal
    localparam int PROD_W      = CH_W + 1 + PCT_W + 1;
    localparam int PPOS_W      = 27;
    localparam int RECIP_W     = 26;
    localparam int RECIP_SHIFT = 32;
    localparam int QUO_W       = PPOS_W + RECIP_W - RECIP_SHIFT;

    localparam logic [RECIP_W-1:0]       DIV100_RECIP = 26'd42949673;
    localparam logic signed [PCT_W:0]    PCT_BASE     = 12'sd100;
    localparam logic [CH_W-1:0]          CH_MAX       = 16'hFFFF;
    localparam logic [DIST_W-1:0]        DIST_INIT    = 32'hFFFF_FFFF;
    localparam logic [DIST_W-1:0]        DIST_MAX     = 32'hC000_0000;
    localparam logic [IDX_W-1:0]         LAST_RESET   = 8'd255;

    typedef logic signed [PCT_W-1:0] t_pct;
    typedef logic [CH_W-1:0]         t_chan;

    typedef enum logic [1:0] {
        ACT_WRITE = 2'd0,
        ACT_MATCH = 2'd1,
        ACT_TINT  = 2'd2
    } t_action;

    typedef enum logic [1:0] {
        REG_LAST  = 2'd0,
        REG_RED   = 2'd1,
        REG_GREEN = 2'd2,
        REG_BLUE  = 2'd3
    } t_reg_idx;

    typedef enum logic [2:0] {
        S_IDLE,
        S_TINT_MUL,
        S_TINT_DIV,
        S_TINT_LOAD,
        S_SEARCH,
        S_DRAIN
    } t_state;

    typedef struct packed {
        logic mem_we;
        logic tint_read;
        logic tint_black;
        logic load_query;
        logic load_tint;
        logic issue;
        logic load_out;
    } t_ctrl_cmd;

    typedef struct packed {
        logic busy;
        logic out_free;
    } t_dp_status;

endpackage

FILE: hdl/ptnm_cfg.sv
// apb-style configuration registers: search bound and per-channel tint percents
// depends on ptnm_pkg
module ptnm_cfg import ptnm_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output logic [IDX_W-1:0]  o_palette_last,
    output t_pct              o_pct_r,
    output t_pct              o_pct_g,
    output t_pct              o_pct_b
);

    logic [IDX_W-1:0] r_last;
    t_pct             r_pct_r;
    t_pct             r_pct_g;
    t_pct             r_pct_b;
    t_reg_idx         reg_idx;
    logic             wr;

    assign reg_idx = t_reg_idx'(paddr[ADDR_W-1:2]);
    assign wr      = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last  <= LAST_RESET;
            r_pct_r <= '0;
            r_pct_g <= '0;
            r_pct_b <= '0;
        end else if (wr) begin
            case (reg_idx)
                REG_LAST:  r_last  <= pwdata[IDX_W-1:0];
                REG_RED:   r_pct_r <= t_pct'(pwdata[PCT_W-1:0]);
                REG_GREEN: r_pct_g <= t_pct'(pwdata[PCT_W-1:0]);
                REG_BLUE:  r_pct_b <= t_pct'(pwdata[PCT_W-1:0]);
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_LAST:  prdata = DATA_W'(r_last);
            REG_RED:   prdata = DATA_W'(r_pct_r);
            REG_GREEN: prdata = DATA_W'(r_pct_g);
            REG_BLUE:  prdata = DATA_W'(r_pct_b);
            default:   prdata = '0;
        endcase
    end

    assign o_palette_last = r_last;
    assign o_pct_r        = r_pct_r;
    assign o_pct_g        = r_pct_g;
    assign o_pct_b        = r_pct_b;

endmodule

FILE: hdl/ptnm_tint.sv
// tint pipeline: scale each channel by (100 + percent), divide by 100, clamp
// depends on ptnm_pkg
module ptnm_tint import ptnm_pkg::*; (
    input  logic               i_clk,
    input  logic [COLOR_W-1:0] i_src_color,
    input  logic               i_src_black,
    input  t_pct               i_pct_r,
    input  t_pct               i_pct_g,
    input  t_pct               i_pct_b,
    output logic [COLOR_W-1:0] o_tint_color
);

    t_pct                           pct     [NUM_CH];
    t_chan                          src     [NUM_CH];
    logic signed [PCT_W:0]          fac     [NUM_CH];
    logic signed [PROD_W-1:0]       n_prod  [NUM_CH];
    logic signed [PROD_W-1:0]       r_prod  [NUM_CH];
    logic [PPOS_W+RECIP_W-1:0]      wide    [NUM_CH];
    logic [QUO_W-1:0]               n_quo   [NUM_CH];
    logic [QUO_W-1:0]               r_quo   [NUM_CH];
    logic                           n_nonpos[NUM_CH];
    logic                           r_nonpos[NUM_CH];

    // channel 0 blue, 1 green, 2 red
    assign pct[0] = i_pct_b;
    assign pct[1] = i_pct_g;
    assign pct[2] = i_pct_r;

    always_comb begin
        for (int c = 0; c < NUM_CH; c++) begin
            src[c]      = i_src_black ? '0 : i_src_color[c*CH_W +: CH_W];
            fac[c]      = {pct[c][PCT_W-1], pct[c]} + PCT_BASE;
            n_prod[c]   = $signed({1'b0, src[c]}) * fac[c];
            n_nonpos[c] = r_prod[c][PROD_W-1] || (r_prod[c] == '0);
            wide[c]     = (PPOS_W+RECIP_W)'(r_prod[c][PPOS_W-1:0])
                          * (PPOS_W+RECIP_W)'(DIV100_RECIP);
            n_quo[c]    = wide[c][PPOS_W+RECIP_W-1:RECIP_SHIFT];
        end
    end

    always_ff @(posedge i_clk) begin
        for (int c = 0; c < NUM_CH; c++) begin
            r_prod[c]   <= n_prod[c];
            r_quo[c]    <= n_quo[c];
            r_nonpos[c] <= n_nonpos[c];
        end
    end

    always_comb begin
        for (int c = 0; c < NUM_CH; c++) begin
            if (r_nonpos[c]) begin
                o_tint_color[c*CH_W +: CH_W] = '0;
            end else if (r_quo[c] > QUO_W'(CH_MAX)) begin
                o_tint_color[c*CH_W +: CH_W] = CH_MAX;
            end else begin
                o_tint_color[c*CH_W +: CH_W] = r_quo[c][CH_W-1:0];
            end
        end
    end

endmodule

FILE: hdl/ptnm_datapath.sv
// palette memory, query registers, distance pipeline, best tracker and output register
// depends on ptnm_pkg and ptnm_tint
module ptnm_datapath import ptnm_pkg::*; #(
    parameter  int unsigned PALETTE_ENTRIES = PALETTE_ENTRIES_DEF,
    localparam int unsigned AW              = $clog2(PALETTE_ENTRIES)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_ctrl_cmd         i_cmd,
    input  logic [AW-1:0]     i_search_addr,
    input  logic [IDX_W-1:0]  i_entry_index,
    input  t_chan             i_red,
    input  t_chan             i_green,
    input  t_chan             i_blue,
    input  t_pct              i_pct_r,
    input  t_pct              i_pct_g,
    input  t_pct              i_pct_b,
    input  logic              i_stall,
    output t_dp_status        o_status,
    output logic              o_valid,
    output logic [IDX_W-1:0]  o_match_index,
    output logic [DIST_W-1:0] o_match_distance
);

    logic [COLOR_W-1:0] r_palette [PALETTE_ENTRIES];
    logic [COLOR_W-1:0] r_rd_data;
    logic [AW-1:0]      rd_addr;
    logic               rd_en;
    logic               r_src_black;
    logic [COLOR_W-1:0] w_tint;
    logic [COLOR_W-1:0] r_query;

    logic               r_p0_vld, r_p1_vld, r_p2_vld, r_p3_vld;
    logic [AW-1:0]      r_p0_idx, r_p1_idx, r_p2_idx, r_p3_idx;
    t_chan              n_m   [NUM_CH];
    t_chan              r_m   [NUM_CH];
    logic [DIST_W-1:0]  r_sq  [NUM_CH];
    logic [DIST_W-1:0]  r_p3_sum;
    logic [CH_W:0]      diff_pos [NUM_CH];
    logic [CH_W:0]      diff_neg [NUM_CH];
    t_chan              ent   [NUM_CH];
    t_chan              qry   [NUM_CH];

    logic [DIST_W-1:0]  r_best_d;
    logic [AW-1:0]      r_best_idx;
    logic               r_out_vld;
    logic [IDX_W-1:0]   r_out_idx;
    logic [DIST_W-1:0]  r_out_dist;

    assign rd_addr = i_cmd.issue ? i_search_addr : i_entry_index[AW-1:0];
    assign rd_en   = i_cmd.issue || i_cmd.tint_read;

    always_ff @(posedge i_clk) begin
        if (i_cmd.mem_we) begin
            r_palette[i_entry_index[AW-1:0]] <= {i_red, i_green, i_blue};
        end
        if (rd_en) begin
            r_rd_data <= r_palette[rd_addr];
        end
        if (i_cmd.tint_read) begin
            r_src_black <= i_cmd.tint_black;
        end
    end

    ptnm_tint u_tint (
        .i_clk        (i_clk),
        .i_src_color  (r_rd_data),
        .i_src_black  (r_src_black),
        .i_pct_r      (i_pct_r),
        .i_pct_g      (i_pct_g),
        .i_pct_b      (i_pct_b),
        .o_tint_color (w_tint)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_query) begin
            r_query <= {i_red, i_green, i_blue};
        end else if (i_cmd.load_tint) begin
            r_query <= w_tint;
        end
    end

    // magnitude of floor((entry - query) / 2)
    always_comb begin
        for (int c = 0; c < NUM_CH; c++) begin
            ent[c]      = r_rd_data[c*CH_W +: CH_W];
            qry[c]      = r_query[c*CH_W +: CH_W];
            diff_pos[c] = {1'b0, ent[c]} - {1'b0, qry[c]};
            diff_neg[c] = {1'b0, qry[c]} - {1'b0, ent[c]} + (CH_W+1)'(1);
            if (ent[c] >= qry[c]) begin
                n_m[c] = diff_pos[c][CH_W:1];
            end else begin
                n_m[c] = diff_neg[c][CH_W:1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p0_vld <= 1'b0;
            r_p1_vld <= 1'b0;
            r_p2_vld <= 1'b0;
            r_p3_vld <= 1'b0;
        end else begin
            r_p0_vld <= i_cmd.issue;
            r_p1_vld <= r_p0_vld;
            r_p2_vld <= r_p1_vld;
            r_p3_vld <= r_p2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_p0_idx <= rd_addr;
        r_p1_idx <= r_p0_idx;
        r_p2_idx <= r_p1_idx;
        r_p3_idx <= r_p2_idx;
        for (int c = 0; c < NUM_CH; c++) begin
            r_m[c]  <= n_m[c];
            r_sq[c] <= DIST_W'(r_m[c]) * DIST_W'(r_m[c]);
        end
        r_p3_sum <= r_sq[0] + r_sq[1] + r_sq[2];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_query || i_cmd.load_tint) begin
            r_best_d   <= DIST_INIT;
            r_best_idx <= '0;
        end else if (r_p3_vld && (r_p3_sum < r_best_d)) begin
            r_best_d   <= r_p3_sum;
            r_best_idx <= r_p3_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_vld <= 1'b1;
        end else if (!i_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_idx  <= IDX_W'(r_best_idx);
            r_out_dist <= r_best_d;
        end
    end

    assign o_status.busy     = r_p0_vld || r_p1_vld || r_p2_vld || r_p3_vld;
    assign o_status.out_free = !r_out_vld || !i_stall;
    assign o_valid           = r_out_vld;
    assign o_match_index     = r_out_idx;
    assign o_match_distance  = r_out_dist;

endmodule

FILE: hdl/ptnm_ctrl.sv
// controller: accepts transactions, sequences tint and the per-entry search, releases results
// depends on ptnm_pkg
module ptnm_ctrl import ptnm_pkg::*; #(
    parameter  int unsigned PALETTE_ENTRIES = PALETTE_ENTRIES_DEF,
    localparam int unsigned AW              = $clog2(PALETTE_ENTRIES)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  logic [1:0]       i_action,
    input  logic [IDX_W-1:0] i_entry_index,
    input  logic [IDX_W-1:0] i_palette_last,
    input  t_dp_status       i_status,
    output t_ctrl_cmd        o_cmd,
    output logic [AW-1:0]    o_search_addr
);

    t_state        r_state, n_state;
    logic [AW-1:0] r_addr, n_addr;
    logic [AW-1:0] last_sat;
    logic          idx_ok;

    assign idx_ok   = {1'b0, i_entry_index} < (IDX_W+1)'(PALETTE_ENTRIES);
    assign last_sat = ({1'b0, i_palette_last} >= (IDX_W+1)'(PALETTE_ENTRIES))
                      ? AW'(PALETTE_ENTRIES - 1) : i_palette_last[AW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_addr  <= '0;
        end else begin
            r_state <= n_state;
            r_addr  <= n_addr;
        end
    end

    always_comb begin
        n_state = r_state;
        n_addr  = r_addr;
        o_cmd   = '0;
        o_stall = (r_state != S_IDLE);
        case (r_state)
            S_IDLE: begin
                n_addr = '0;
                if (i_valid) begin
                    case (t_action'(i_action))
                        ACT_WRITE: begin
                            o_cmd.mem_we = idx_ok;
                        end
                        ACT_MATCH: begin
                            o_cmd.load_query = 1'b1;
                            n_state          = S_SEARCH;
                        end
                        ACT_TINT: begin
                            o_cmd.tint_read  = 1'b1;
                            o_cmd.tint_black = !idx_ok;
                            n_state          = S_TINT_MUL;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_TINT_MUL: begin
                n_state = S_TINT_DIV;
            end
            S_TINT_DIV: begin
                n_state = S_TINT_LOAD;
            end
            S_TINT_LOAD: begin
                o_cmd.load_tint = 1'b1;
                n_state         = S_SEARCH;
            end
            S_SEARCH: begin
                o_cmd.issue = 1'b1;
                if (r_addr == last_sat) begin
                    n_state = S_DRAIN;
                end else begin
                    n_addr = AW'(r_addr + 1'b1);
                end
            end
            S_DRAIN: begin
                if (!i_status.busy && i_status.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_search_addr = r_addr;

endmodule

FILE: hdl/palette_tint_nearest_match.sv
// nearest palette color search with optional per-channel percent tint of a stored entry
// write: stored on accept; direct match: searches entries 0 to palette_last, then releases
// the result once the output is free; tinted match: tint multiply, divide, load come first
// one palette entry per cycle through the memory read port and a diff, square, sum pipeline
// a new input transaction is taken while a finished result still waits at the output
// synchronous active-low reset clears control and config registers; palette is not cleared
// depends on ptnm_pkg, ptnm_cfg, ptnm_ctrl, ptnm_datapath, ptnm_tint
module palette_tint_nearest_match import ptnm_pkg::*; #(
    parameter int unsigned PALETTE_ENTRIES = PALETTE_ENTRIES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [1:0]        i_action,
    input  logic [IDX_W-1:0]  i_entry_index,
    input  logic [CH_W-1:0]   i_red,
    input  logic [CH_W-1:0]   i_green,
    input  logic [CH_W-1:0]   i_blue,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [IDX_W-1:0]  o_match_index,
    output logic [DIST_W-1:0] o_match_distance,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    localparam int unsigned AW = $clog2(PALETTE_ENTRIES);

    logic [IDX_W-1:0] w_palette_last;
    t_pct             w_pct_r;
    t_pct             w_pct_g;
    t_pct             w_pct_b;
    t_ctrl_cmd        w_cmd;
    t_dp_status       w_status;
    logic [AW-1:0]    w_search_addr;

    ptnm_cfg u_cfg (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .o_palette_last (w_palette_last),
        .o_pct_r        (w_pct_r),
        .o_pct_g        (w_pct_g),
        .o_pct_b        (w_pct_b)
    );

    ptnm_ctrl #(
        .PALETTE_ENTRIES (PALETTE_ENTRIES)
    ) u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_action       (i_action),
        .i_entry_index  (i_entry_index),
        .i_palette_last (w_palette_last),
        .i_status       (w_status),
        .o_cmd          (w_cmd),
        .o_search_addr  (w_search_addr)
    );

    ptnm_datapath #(
        .PALETTE_ENTRIES (PALETTE_ENTRIES)
    ) u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .i_search_addr    (w_search_addr),
        .i_entry_index    (i_entry_index),
        .i_red            (i_red),
        .i_green          (i_green),
        .i_blue           (i_blue),
        .i_pct_r          (w_pct_r),
        .i_pct_g          (w_pct_g),
        .i_pct_b          (w_pct_b),
        .i_stall          (i_stall),
        .o_status         (w_status),
        .o_valid          (o_valid),
        .o_match_index    (o_match_index),
        .o_match_distance (o_match_distance)
    );

    // a result only appears at the end of a search, while the input side is held
    a_result_after_search: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(o_stall))
        else $error("result released without a search in flight");

    a_index_in_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> (o_match_index <= w_palette_last))
        else $error("match index beyond search bound");

    a_distance_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> (o_match_distance <= DIST_MAX))
        else $error("match distance out of range, no entry was compared");

endmodule

FILE: tb/sv/tb_top.sv
// self-checking testbench for palette_tint_nearest_match: directed and random transactions
// with its own nearest-color predictor, random idling and one long receiver hold-off
// depends on ptnm_pkg and palette_tint_nearest_match
module tb_top;
    import ptnm_pkg::*;

    localparam logic [1:0] ACT_IGNORED  = 2'd3;
    localparam int         LIMIT_CYCLES = 1200000;
    localparam int         HOLD_CYCLES  = 1500;

    typedef struct packed {
        t_chan r;
        t_chan g;
        t_chan b;
    } t_rgb;

    typedef struct packed {
        logic [1:0]       action;
        logic [IDX_W-1:0] entry;
        t_rgb             color;
    } t_palette_op;

    typedef struct packed {
        logic [IDX_W-1:0]  idx;
        logic [DIST_W-1:0] distance;
    } t_nearest;

    logic              i_clk            = 1'b0;
    logic              i_rst_n          = 1'b0;
    logic              i_valid          = 1'b0;
    logic              o_stall;
    logic [1:0]        i_action         = '0;
    logic [IDX_W-1:0]  i_entry_index    = '0;
    logic [CH_W-1:0]   i_red            = '0;
    logic [CH_W-1:0]   i_green          = '0;
    logic [CH_W-1:0]   i_blue           = '0;
    logic              o_valid;
    logic              i_stall          = 1'b1;
    logic [IDX_W-1:0]  o_match_index;
    logic [DIST_W-1:0] o_match_distance;
    logic              psel             = 1'b0;
    logic              penable          = 1'b0;
    logic              pwrite           = 1'b0;
    logic [ADDR_W-1:0] paddr            = '0;
    logic [DATA_W-1:0] pwdata           = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    // predictor state
    t_rgb              palette_copy [PALETTE_ENTRIES_DEF];
    logic [IDX_W-1:0]  search_last = LAST_RESET;
    t_pct              tint_pct [3] = '{default: '0};
    t_nearest          nearest_expected [$];

    // stimulus state
    t_palette_op       palette_ops_pending [$];
    t_palette_op       in_flight;
    logic              entry_written [PALETTE_ENTRIES_DEF] = '{default: 1'b0};
    t_rgb              recent_color = '0;
    int                ops_queued = 0;
    int                ops_taken = 0;
    int                sender_idle_pct = 0;
    int                recv_stall_pct = 0;
    logic              hold_req = 1'b0;
    logic              hold_done = 1'b0;
    int                hold_left = 0;
    int                error_count = 0;
    int                cycle_count = 0;

    palette_tint_nearest_match i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_action         (i_action),
        .i_entry_index    (i_entry_index),
        .i_red            (i_red),
        .i_green          (i_green),
        .i_blue           (i_blue),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_match_index    (o_match_index),
        .o_match_distance (o_match_distance),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    function automatic t_chan tint_chan(t_chan c, t_pct p);
        longint prod;
        longint quo;
        prod = longint'(c) * (longint'(100) + longint'(p));
        if (prod <= 0) return '0;
        quo = prod / 100;
        if (quo > longint'(CH_MAX)) return CH_MAX;
        return t_chan'(quo);
    endfunction

    function automatic logic [DIST_W-1:0] half_sq(t_chan e, t_chan q);
        logic [CH_W:0] m;
        if (e >= q) m = ({1'b0, e} - {1'b0, q}) >> 1;
        else        m = ({1'b0, q} - {1'b0, e} + 1'b1) >> 1;
        return DIST_W'(m) * DIST_W'(m);
    endfunction

    function automatic void apply_palette_op(t_palette_op op);
        t_rgb              q;
        t_rgb              src;
        logic [DIST_W-1:0] best_d;
        logic [DIST_W-1:0] d;
        int                best;
        q = op.color;
        case (op.action)
            ACT_WRITE: begin
                palette_copy[op.entry] = op.color;
                return;
            end
            ACT_MATCH: ;
            ACT_TINT: begin
                src = palette_copy[op.entry];
                q.r = tint_chan(src.r, tint_pct[0]);
                q.g = tint_chan(src.g, tint_pct[1]);
                q.b = tint_chan(src.b, tint_pct[2]);
            end
            default: return;
        endcase
        best_d = DIST_INIT;
        best = 0;
        for (int i = 0; i <= int'(search_last); i++) begin
            d = half_sq(palette_copy[i].r, q.r) + half_sq(palette_copy[i].g, q.g)
                + half_sq(palette_copy[i].b, q.b);
            if (d < best_d) begin
                best_d = d;
                best = i;
            end
        end
        nearest_expected.push_back('{IDX_W'(best), best_d});
    endfunction

    // driver: one transaction offered at a time, payload held while stalled
    always @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            apply_palette_op(in_flight);
            ops_taken++;
        end
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || !o_stall) begin
            if (palette_ops_pending.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
                in_flight = palette_ops_pending.pop_front();
                i_valid       <= 1'b1;
                i_action      <= in_flight.action;
                i_entry_index <= in_flight.entry;
                i_red         <= in_flight.color.r;
                i_green       <= in_flight.color.g;
                i_blue        <= in_flight.color.b;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // monitor and receiver stall
    always @(posedge i_clk) begin
        t_nearest want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (nearest_expected.size() == 0) begin
                $display("%0t: unexpected result: index %0d distance %0d",
                         $time, o_match_index, o_match_distance);
                error_count++;
            end else begin
                want = nearest_expected.pop_front();
                if (o_match_index !== want.idx) begin
                    $display("%0t: match_index expected %0d actual %0d",
                             $time, want.idx, o_match_index);
                    error_count++;
                end
                if (o_match_distance !== want.distance) begin
                    $display("%0t: match_distance expected %0d actual %0d",
                             $time, want.distance, o_match_distance);
                    error_count++;
                end
            end
        end
        if (hold_req && !hold_done) begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    task automatic queue_op(logic [1:0] act, int idx, t_rgb c);
        palette_ops_pending.push_back('{act, IDX_W'(idx), c});
        ops_queued++;
        if (act == ACT_WRITE) entry_written[idx] = 1'b1;
    endtask

    task automatic wait_idle();
        while (ops_taken != ops_queued || nearest_expected.size() != 0) @(posedge i_clk);
        repeat (int'(search_last) + 20) @(posedge i_clk);
    endtask

    task automatic write_reg(t_reg_idx r, logic [DATA_W-1:0] v);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'(r) << 2;
        pwdata  <= v;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (r == REG_LAST) search_last = v[IDX_W-1:0];
        else tint_pct[int'(r) - 1] = v[PCT_W-1:0];
    endtask

    task automatic set_config(int last, int pr, int pg, int pb);
        wait_idle();
        write_reg(REG_LAST, DATA_W'(last));
        write_reg(REG_RED, DATA_W'(pr));
        write_reg(REG_GREEN, DATA_W'(pg));
        write_reg(REG_BLUE, DATA_W'(pb));
    endtask

    function automatic t_chan rand_chan();
        case ($urandom_range(7))
            0:       return '0;
            1:       return CH_MAX;
            2:       return t_chan'($urandom_range(3));
            3:       return CH_MAX - t_chan'($urandom_range(3));
            default: return t_chan'($urandom);
        endcase
    endfunction

    function automatic t_rgb rand_rgb();
        t_rgb c;
        c.r = rand_chan();
        c.g = rand_chan();
        c.b = rand_chan();
        return c;
    endfunction

    function automatic int rand_pct();
        case ($urandom_range(6))
            0:       return -100;
            1:       return 900;
            2:       return -1024;
            3:       return 1023;
            4:       return 0;
            default: return int'($urandom_range(2047)) - 1024;
        endcase
    endfunction

    // palette entries up to the search bound are written before any lookup
    task automatic random_segment(int n);
        int   pick;
        int   idx;
        t_rgb c;
        for (int i = 0; i <= int'(search_last); i++)
            if (!entry_written[i]) queue_op(ACT_WRITE, i, rand_rgb());
        repeat (n) begin
            pick = $urandom_range(99);
            if (pick < 25) begin
                if ($urandom_range(9) < 6) idx = $urandom_range(int'(search_last));
                else idx = $urandom_range(PALETTE_ENTRIES_DEF - 1);
                c = rand_rgb();
                recent_color = c;
                queue_op(ACT_WRITE, idx, c);
            end else if (pick < 60) begin
                c = ($urandom_range(3) == 0) ? recent_color : rand_rgb();
                queue_op(ACT_MATCH, $urandom_range(PALETTE_ENTRIES_DEF - 1), c);
            end else if (pick < 95) begin
                idx = $urandom_range(PALETTE_ENTRIES_DEF - 1);
                if (!entry_written[idx]) idx = idx % (int'(search_last) + 1);
                queue_op(ACT_TINT, idx, rand_rgb());
            end else begin
                queue_op(ACT_IGNORED, $urandom_range(PALETTE_ENTRIES_DEF - 1), rand_rgb());
            end
        end
    endtask

    initial begin
        int last_sel;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: channel extremes, tie on lowest index, odd differences, clamped tints
        set_config(3, 900, -100, 50);
        queue_op(ACT_WRITE, 0, '{16'h0000, 16'h0000, 16'h0000});
        queue_op(ACT_WRITE, 1, '{16'hFFFF, 16'hFFFF, 16'hFFFF});
        queue_op(ACT_WRITE, 2, '{16'h8000, 16'h7FFF, 16'h1234});
        queue_op(ACT_WRITE, 3, '{16'hFFFF, 16'hFFFF, 16'hFFFF});
        queue_op(ACT_WRITE, 255, '{16'hFFFF, 16'h0000, 16'hAAAA});
        queue_op(ACT_MATCH, 0, '{16'h0000, 16'h0000, 16'h0000});
        queue_op(ACT_MATCH, 255, '{16'hFFFF, 16'hFFFF, 16'hFFFF});
        queue_op(ACT_MATCH, 7, '{16'h0001, 16'h0001, 16'h0001});
        queue_op(ACT_MATCH, 0, '{16'hFFFF, 16'h0000, 16'h8000});
        queue_op(ACT_TINT, 1, '{16'h0000, 16'h0000, 16'h0000});
        queue_op(ACT_TINT, 2, '{16'hFFFF, 16'hFFFF, 16'hFFFF});
        queue_op(ACT_TINT, 255, '{16'h0000, 16'h0000, 16'h0000});
        queue_op(ACT_IGNORED, 0, '{16'hFFFF, 16'hFFFF, 16'hFFFF});
        queue_op(ACT_TINT, 0, '{16'h5555, 16'hAAAA, 16'h5555});

        // single-entry search, percents at the 11-bit signed limits and below -100
        set_config(0, 1023, -1024, -101);
        queue_op(ACT_MATCH, 128, '{16'h5555, 16'hAAAA, 16'hFFFF});
        queue_op(ACT_TINT, 2, '{16'h0000, 16'h0000, 16'h0000});
        queue_op(ACT_WRITE, 0, '{16'h1234, 16'h5678, 16'h9ABC});
        queue_op(ACT_TINT, 0, '{16'h0000, 16'h0000, 16'h0000});
        queue_op(ACT_MATCH, 0, '{16'h0000, 16'h0000, 16'h0000});

        for (int seg = 0; seg < 8; seg++) begin
            case (seg)
                0:       last_sel = 7;
                1:       last_sel = 15;
                2:       last_sel = 255;
                3:       last_sel = 1;
                4:       last_sel = 0;
                default: last_sel = $urandom_range(31);
            endcase
            if (seg == 4) set_config(last_sel, -100, 900, -100);
            else set_config(last_sel, rand_pct(), rand_pct(), rand_pct());
            case (seg % 4)
                0: begin
                    sender_idle_pct <= 0;
                    recv_stall_pct  <= 0;
                end
                1: begin
                    sender_idle_pct <= 74;
                    recv_stall_pct  <= 0;
                end
                2: begin
                    sender_idle_pct <= 0;
                    recv_stall_pct  <= 74;
                end
                default: begin
                    sender_idle_pct <= 23;
                    recv_stall_pct  <= 23;
                end
            endcase
            if (seg == 0) hold_req <= 1'b1;
            random_segment(seg == 2 ? 30 : 110);
        end

        wait_idle();
        if (error_count == 0 && nearest_expected.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("%0d errors, %0d results never arrived",
                     error_count, nearest_expected.size());
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

FILE: files.f
hdl/ptnm_pkg.sv
hdl/ptnm_cfg.sv
hdl/ptnm_tint.sv
hdl/ptnm_datapath.sv
hdl/ptnm_ctrl.sv
hdl/palette_tint_nearest_match.sv
tb/sv/tb_top.sv
